// File: hw/rtl/wppe_pkg.sv
// Shared types and constants of the WS2812 pixel pulse encoder.
// Used by wppe_scaler and the top level ws2812_pixel_pulse_encoder.
`default_nettype none

package wppe_pkg;

  localparam int CHAN_W      = 8;
  localparam int PIX_BITS    = 24;
  localparam int BIT_CNT_W   = 5;
  localparam int PCT_W       = 8;
  localparam int DUTY_W      = 16;

  // Shared multiplier operand width. floor(p / 100) for p < 2**16 equals
  // (p * 83887) >> 23, because the error term stays below 1/100.
  localparam int MUL_W       = 17;
  localparam int RECIP_SHIFT = 23;
  localparam logic [MUL_W-1:0] RECIP_100 = 17'd83887;
  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

  // Input item kinds carried on tuser.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_HIGH_DUTY = 1'b0;
  localparam logic CFG_LOW_DUTY  = 1'b1;

  typedef struct packed {
    logic                start;
    logic [PIX_BITS-1:0] color;
    logic [PCT_W-1:0]    pct;
  } scl_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } scl_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/wppe_scaler.sv
// Brightness scaler: one shared 17x17 multiplier scales R, G and B in turn.
// Depends on wppe_pkg; the result is packed in G,R,B order.
`default_nettype none

module wppe_scaler (
  input  wire                                clk,
  input  wire                                rst,
  input  wire  wppe_pkg::scl_req_t           req,
  output wppe_pkg::scl_stat_t                stat,
  output logic [wppe_pkg::PIX_BITS-1:0]      pixel
);
  import wppe_pkg::*;

  localparam logic [1:0] PH_MUL   = 2'd0;
  localparam logic [1:0] PH_RECIP = 2'd1;
  localparam logic [1:0] PH_SAT   = 2'd2;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  localparam int QUOT_W = 2 * MUL_W - RECIP_SHIFT;

  logic                 busy;
  logic                 done;
  logic [1:0]           phase;
  logic [1:0]           chan;
  logic [PIX_BITS-1:0]  color;
  logic [PCT_W-1:0]     pct;
  logic [2*MUL_W-1:0]   prod;

  logic [CHAN_W-1:0]    ch_sel;
  logic [MUL_W-1:0]     mul_a;
  logic [MUL_W-1:0]     mul_b;
  logic [2*MUL_W-1:0]   mul_out;
  logic [QUOT_W-1:0]    quot;
  logic [CHAN_W-1:0]    sat;

  always_comb begin
    case (chan)
      CH_RED:   ch_sel = color[23:16];
      CH_GREEN: ch_sel = color[15:8];
      default:  ch_sel = color[7:0];
    endcase
  end

  // First pass forms channel * percent, second pass divides by 100.
  assign mul_a   = (phase == PH_MUL) ? {{(MUL_W-CHAN_W){1'b0}}, ch_sel} : prod[MUL_W-1:0];
  assign mul_b   = (phase == PH_MUL) ? {{(MUL_W-PCT_W){1'b0}}, pct} : RECIP_100;
  assign mul_out = mul_a * mul_b;
  assign quot    = prod[2*MUL_W-1:RECIP_SHIFT];
  assign sat     = (quot > QUOT_W'(CHAN_MAX)) ? CHAN_MAX : quot[CHAN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= PH_MUL;
      chan  <= CH_RED;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        phase <= PH_MUL;
        chan  <= CH_RED;
      end else if (busy) begin
        case (phase)
          PH_MUL:   phase <= PH_RECIP;
          PH_RECIP: phase <= PH_SAT;
          default: begin
            phase <= PH_MUL;
            chan  <= chan + 2'd1;
            if (chan == CH_BLUE) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      color <= req.color;
      pct   <= req.pct;
    end
    if (busy && (phase != PH_SAT)) begin
      prod <= mul_out;
    end
    if (busy && (phase == PH_SAT)) begin
      case (chan)
        CH_RED:   pixel[15:8]  <= sat;
        CH_GREEN: pixel[23:16] <= sat;
        default:  pixel[7:0]   <= sat;
      endcase
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

// File: hw/rtl/ws2812_pixel_pulse_encoder.sv
// Top level of the WS2812 pixel pulse encoder: pixel store, read sequencer
// and output register. Depends on wppe_pkg and wppe_scaler.
//
//   Channel   Direction  Beat contents
//   s_axis    in         tuser: func; tdata: slot, color, brightness
//   m_axis    out        tdata: duty; tlast: last_bit
//   cfg       in         cfg_index 0 high_duty, 1 low_duty
//
// A write item passes through the accept cycle, the scaler (multiply, divide
// and saturate for each channel) and a store of the pixel.
// A read item passes through the accept cycle, one store read, one load,
// then one pulse beat per cycle; a beat that waits while m_axis_tready is
// low stalls the sequence.
// rst is synchronous and clears the written flags; the store itself needs
// no clearing pass. s_axis_tready is high only while the sequencer is idle.
`default_nettype none

module ws2812_pixel_pulse_encoder #(
  parameter int LED_COUNT = 15
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire  [39:0]                         s_axis_tdata,  // slot, color, brightness
  input  wire                                 s_axis_tuser,  // func
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  output logic [wppe_pkg::DUTY_W-1:0]         m_axis_tdata,  // duty
  output logic                                m_axis_tlast,
  input  wire                                 cfg_we,
  input  wire                                 cfg_index,
  input  wire  [wppe_pkg::DUTY_W-1:0]         cfg_data
);
  import wppe_pkg::*;

  // The index field is four bits wide, so at most 16 slots are reachable.
  localparam int DEPTH = (LED_COUNT < 16) ? LED_COUNT : 16;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W = 11;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCALE = 3'd1;
  localparam logic [2:0] ST_FETCH = 3'd2;
  localparam logic [2:0] ST_LOAD  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]            state;
  logic [3:0]            idx;
  logic                  in_range;
  logic                  live;
  logic [PIX_BITS-1:0]   shift;
  logic [BIT_CNT_W-1:0]  bit_cnt;
  logic [DUTY_W-1:0]     high_duty;
  logic [DUTY_W-1:0]     low_duty;
  logic [DEPTH-1:0]      written;
  logic [PIX_BITS-1:0]   mem [DEPTH];
  logic [PIX_BITS-1:0]   mem_q;

  logic [3:0]            in_idx;
  logic                  in_ok;
  logic                  accept;
  logic                  emit_go;
  logic                  store_go;
  logic [AW-1:0]         addr;
  scl_req_t              scl_req;
  scl_stat_t             scl_stat;
  logic [PIX_BITS-1:0]   scl_pixel;

  assign in_idx   = s_axis_tdata[3:0];
  assign in_ok    = ({{(CMP_W-4){1'b0}}, in_idx} < CMP_W'(LED_COUNT));
  assign s_axis_tready = (state == ST_IDLE);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign emit_go  = (state == ST_EMIT) && (!m_axis_tvalid || m_axis_tready);
  assign store_go = (state == ST_SCALE) && scl_stat.done;
  assign addr     = idx[AW-1:0];

  assign scl_req.start = accept && (s_axis_tuser == FUNC_WRITE) && in_ok;
  assign scl_req.color = s_axis_tdata[27:4];
  assign scl_req.pct   = s_axis_tdata[35:28];

  wppe_scaler u_scaler (
    .clk   (clk),
    .rst   (rst),
    .req   (scl_req),
    .stat  (scl_stat),
    .pixel (scl_pixel)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      written       <= '0;
      high_duty     <= 16'd229;
      low_duty      <= 16'd113;
      m_axis_tvalid <= 1'b0;
      bit_cnt       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HIGH_DUTY: high_duty <= cfg_data;
          default:       low_duty  <= cfg_data;
        endcase
      end
      if (emit_go) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (s_axis_tuser == FUNC_READ) begin
              state <= ST_FETCH;
            end else if (in_ok) begin
              state <= ST_SCALE;
            end
          end
        end
        ST_SCALE: begin
          if (scl_stat.done) begin
            written[addr] <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        ST_FETCH: state <= ST_LOAD;
        ST_LOAD: begin
          bit_cnt <= '0;
          state   <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_go) begin
            bit_cnt <= bit_cnt + 1'b1;
            if (bit_cnt == BIT_CNT_W'(PIX_BITS - 1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Pixel store and the beat payload path.
  always_ff @(posedge clk) begin
    if (accept) begin
      idx      <= in_idx;
      in_range <= in_ok;
    end
    if (store_go) begin
      mem[addr] <= scl_pixel;
    end
    mem_q <= mem[addr];
    if (state == ST_LOAD) begin
      shift <= mem_q;
      live  <= in_range && written[addr];
    end
    if (emit_go) begin
      shift        <= {shift[PIX_BITS-2:0], 1'b0};
      m_axis_tdata <= !live ? '0 : (shift[PIX_BITS-1] ? high_duty : low_duty);
      m_axis_tlast <= (bit_cnt == BIT_CNT_W'(PIX_BITS - 1));
    end
  end

  // The scaler only runs while the sequencer waits for it.
  a_scale_owned: assert property (@(posedge clk) disable iff (rst)
    scl_stat.busy |-> (state == ST_SCALE))
    else $error("scaler busy outside the scale state");

  // A done pulse must land while the store write is pending.
  a_done_in_scale: assert property (@(posedge clk) disable iff (rst)
    scl_stat.done |-> (state == ST_SCALE))
    else $error("scaler done outside the scale state");

  // The pulse counter never runs past the last bit of a pixel.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (bit_cnt <= BIT_CNT_W'(PIX_BITS - 1)))
    else $error("pulse counter out of range");

  // The last pulse of a pixel returns the sequencer to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (emit_go && (bit_cnt == BIT_CNT_W'(PIX_BITS - 1))) |=> (state == ST_IDLE))
    else $error("sequencer did not finish after the last pulse");

endmodule

`default_nettype wire
